/* rtl/svdsv_pkg.sv */
// ----------------------------------------------------------------------------
// svdsv_pkg
// shared constants of the 2x2 singular value solver
// ----------------------------------------------------------------------------
package svdsv_pkg;

   localparam int TOL_WIDTH = 32;

   typedef logic [TOL_WIDTH-1:0] tol_type;

endpackage

/* rtl/svdsv_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// svdsv_sqrt_cell
// one radix-2 step of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module svdsv_sqrt_cell #(
   parameter int RW = 33
) (
   input  logic            clock,
   input  logic            advance,
   input  logic [RW+1:0]   in_rem,
   input  logic [RW-1:0]   in_root,
   input  logic [2*RW-1:0] in_rad,
   output logic [RW+1:0]   out_rem,
   output logic [RW-1:0]   out_root,
   output logic [2*RW-1:0] out_rad
);
   logic [RW+3:0]   part;
   logic [RW+3:0]   trial;
   logic            take;
   logic [RW+1:0]   rem_in;
   logic [RW-1:0]   root_in;
   logic [2*RW-1:0] rad_in;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [2*RW-1:0] rad_ff;

   always_comb begin
      part    = {in_rem, in_rad[2*RW-1 -: 2]};
      trial   = (RW+4)'({in_root, 2'b01});
      take    = part >= trial;
      rem_in  = take ? (RW+2)'(part - trial) : (RW+2)'(part);
      root_in = {in_root[RW-2:0], take};
      rad_in  = in_rad << 2;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_rad  = rad_ff;
endmodule

/* rtl/svdsv_div_cell.sv */
// ----------------------------------------------------------------------------
// svdsv_div_cell
// one step of a restoring unsigned division, registered
// ----------------------------------------------------------------------------
module svdsv_div_cell #(
   parameter int DW = 65,
   parameter int QW = 32
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_quo,
   input  logic [QW-1:0] in_low,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_den,
   output logic [QW-1:0] out_quo,
   output logic [QW-1:0] out_low
);
   logic [DW:0]   part;
   logic          take;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] quo_in;
   logic [QW-1:0] low_in;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] low_ff;

   always_comb begin
      part   = {in_rem, in_low[QW-1]};
      take   = part >= {1'b0, in_den};
      rem_in = take ? DW'(part - {1'b0, in_den}) : DW'(part);
      quo_in = {in_quo[QW-2:0], take};
      low_in = in_low << 1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
         low_ff <= low_in;
      end
   end

   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_quo = quo_ff;
   assign out_low = low_ff;
endmodule

/* rtl/svd_solve_2x2_with_singular_values_unit.sv */
// ----------------------------------------------------------------------------
// svd_solve_2x2_with_singular_values_unit
// 2x2 linear solve through closed-form singular values
// ----------------------------------------------------------------------------
// A matrix and right-hand side transfer on the req_ channel; one result
// transfers on the rsp_ channel per item: both singular values, the solution
// and the solvable flag. csr_wr_en writes the relative tolerance.
// The datapath is one pipeline: four front stages (sums, squares,
// numerators), a chain of DATA_WIDTH+1 square root cells, three stages for
// the singular values, tolerance test and divisor, a chain of DATA_WIDTH
// divider cells and the output register; one item is taken every cycle
// unless rsp_stall holds the pipeline.
// While a result waits under rsp_stall the whole pipeline holds and
// req_stall is high; otherwise a new item transfers each cycle, also while
// the output register still shows a result that is taken in that cycle.
// Reset clears all valid bits and sets the tolerance to 1.
// ----------------------------------------------------------------------------
module svd_solve_2x2_with_singular_values_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_m00,
   input  logic signed [DATA_WIDTH-1:0]  req_m01,
   input  logic signed [DATA_WIDTH-1:0]  req_m10,
   input  logic signed [DATA_WIDTH-1:0]  req_m11,
   input  logic signed [DATA_WIDTH-1:0]  req_rhs0,
   input  logic signed [DATA_WIDTH-1:0]  req_rhs1,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_sol0,
   output logic signed [DATA_WIDTH-1:0]  rsp_sol1,
   output logic        [DATA_WIDTH-1:0]  rsp_sing_large,
   output logic signed [DATA_WIDTH-1:0]  rsp_sing_small,
   output logic                          rsp_solvable,
   input  logic                          csr_wr_en,
   input  svdsv_pkg::tol_type            csr_wr_data
);
   import svdsv_pkg::*;

   localparam int D  = DATA_WIDTH;
   localparam int RW = D + 1;
   localparam int SW = 2 * RW;
   localparam int NW = 2 * D + 1;
   localparam int DW = 2 * D + 1;
   localparam int MW = NW + FRAC_BITS;
   localparam int TW = TOL_WIDTH + D + 1;
   localparam int XW = (MW > DW + D) ? MW : DW + D;

   logic    advance;
   tol_type tol_ff;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tol_type'(1);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // stage 1: input transfer
   logic v1_ff;
   logic signed [D-1:0] a00_ff, a01_ff, a10_ff, a11_ff, b0_ff, b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a00_ff <= req_m00;
         a01_ff <= req_m01;
         a10_ff <= req_m10;
         a11_ff <= req_m11;
         b0_ff  <= req_rhs0;
         b1_ff  <= req_rhs1;
      end
   end

   // stage 2: sum and difference magnitudes, cramer products
   logic v2_ff;
   logic signed [D:0] e_s, f_s, g_s, h_s;
   logic [D:0] ae_in, af_in, ag_in, ah_in, ae_ff, af_ff, ag_ff, ah_ff;
   logic signed [2*D-1:0] pa_ff, pb_ff, pc_ff, pd_ff;

   always_comb begin
      e_s   = (D+1)'(a00_ff) + (D+1)'(a11_ff);
      f_s   = (D+1)'(a00_ff) - (D+1)'(a11_ff);
      g_s   = (D+1)'(a01_ff) + (D+1)'(a10_ff);
      h_s   = (D+1)'(a01_ff) - (D+1)'(a10_ff);
      ae_in = e_s[D] ? (D+1)'(-e_s) : (D+1)'(e_s);
      af_in = f_s[D] ? (D+1)'(-f_s) : (D+1)'(f_s);
      ag_in = g_s[D] ? (D+1)'(-g_s) : (D+1)'(g_s);
      ah_in = h_s[D] ? (D+1)'(-h_s) : (D+1)'(h_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ae_ff <= ae_in;
         af_ff <= af_in;
         ag_ff <= ag_in;
         ah_ff <= ah_in;
         pa_ff <= b0_ff * a11_ff;
         pb_ff <= b1_ff * a01_ff;
         pc_ff <= a00_ff * b1_ff;
         pd_ff <= a10_ff * b0_ff;
      end
   end

   // stage 3: squares and numerators
   logic v3_ff;
   logic [SW-1:0] se_ff, sf_ff, sg_ff, sh_ff;
   logic signed [NW-1:0] n0_3_ff, n1_3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         se_ff   <= SW'(ae_ff) * SW'(ae_ff);
         sf_ff   <= SW'(af_ff) * SW'(af_ff);
         sg_ff   <= SW'(ag_ff) * SW'(ag_ff);
         sh_ff   <= SW'(ah_ff) * SW'(ah_ff);
         n0_3_ff <= NW'(pa_ff) - NW'(pb_ff);
         n1_3_ff <= NW'(pc_ff) - NW'(pd_ff);
      end
   end

   // stage 4: sums of squares
   logic v4_ff;
   logic [SW-1:0] seh_ff, sfg_ff;
   logic signed [NW-1:0] n0_4_ff, n1_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seh_ff  <= se_ff + sh_ff;
         sfg_ff  <= sf_ff + sg_ff;
         n0_4_ff <= n0_3_ff;
         n1_4_ff <= n1_3_ff;
      end
   end

   // square root chains
   logic [RW+1:0]   eh_rem  [RW+1];
   logic [RW-1:0]   eh_root [RW+1];
   logic [SW-1:0]   eh_rad  [RW+1];
   logic [RW+1:0]   fg_rem  [RW+1];
   logic [RW-1:0]   fg_root [RW+1];
   logic [SW-1:0]   fg_rad  [RW+1];
   logic            sq_v_ff  [RW+1];
   logic [NW-1:0]   sq_n0_ff [RW+1];
   logic [NW-1:0]   sq_n1_ff [RW+1];

   assign eh_rem[0]  = '0;
   assign eh_root[0] = '0;
   assign eh_rad[0]  = seh_ff;
   assign fg_rem[0]  = '0;
   assign fg_root[0] = '0;
   assign fg_rad[0]  = sfg_ff;

   always_comb begin
      sq_v_ff[0]  = v4_ff;
      sq_n0_ff[0] = n0_4_ff;
      sq_n1_ff[0] = n1_4_ff;
   end

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      svdsv_sqrt_cell #(.RW(RW)) u_eh (
         .clock    (clock),
         .advance  (advance),
         .in_rem   (eh_rem[i]),
         .in_root  (eh_root[i]),
         .in_rad   (eh_rad[i]),
         .out_rem  (eh_rem[i+1]),
         .out_root (eh_root[i+1]),
         .out_rad  (eh_rad[i+1])
      );
      svdsv_sqrt_cell #(.RW(RW)) u_fg (
         .clock    (clock),
         .advance  (advance),
         .in_rem   (fg_rem[i]),
         .in_root  (fg_root[i]),
         .in_rad   (fg_rad[i]),
         .out_rem  (fg_rem[i+1]),
         .out_root (fg_root[i+1]),
         .out_rad  (fg_rad[i+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_n0_ff[i+1] <= sq_n0_ff[i];
            sq_n1_ff[i+1] <= sq_n1_ff[i];
         end
      end
   end

   // stage a: singular values
   logic va_ff;
   logic [D-1:0] reh, rfg;
   logic [D:0] wl_in, wl_a_ff;
   logic signed [D:0] ws_in, ws_a_ff;
   logic [D-1:0] aws_in, aws_a_ff;
   logic [NW-1:0] n0_a_ff, n1_a_ff;

   always_comb begin
      reh    = eh_root[RW][RW-1:1];
      rfg    = fg_root[RW][RW-1:1];
      wl_in  = (D+1)'(reh) + (D+1)'(rfg);
      ws_in  = signed'((D+1)'(reh) - (D+1)'(rfg));
      aws_in = ws_in[D] ? D'(-ws_in) : D'(ws_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= sq_v_ff[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wl_a_ff  <= wl_in;
         ws_a_ff  <= ws_in;
         aws_a_ff <= aws_in;
         n0_a_ff  <= sq_n0_ff[RW];
         n1_a_ff  <= sq_n1_ff[RW];
      end
   end

   // stage b: tolerance product, divisor, numerator magnitudes
   logic vb_ff;
   logic [TW-1:0] tolp_ff;
   logic [DW-1:0] den_b_ff;
   logic [MW-1:0] mag0_ff, mag1_ff;
   logic neg0_b_ff, neg1_b_ff;
   logic [D:0] wl_b_ff;
   logic signed [D:0] ws_b_ff;
   logic [D-1:0] aws_b_ff;
   logic [NW-1:0] abs0, abs1;

   always_comb begin
      abs0 = n0_a_ff[NW-1] ? NW'(-n0_a_ff) : n0_a_ff;
      abs1 = n1_a_ff[NW-1] ? NW'(-n1_a_ff) : n1_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tolp_ff   <= TW'(tol_ff) * TW'(wl_a_ff);
         den_b_ff  <= DW'(wl_a_ff) * DW'(aws_a_ff);
         mag0_ff   <= MW'(abs0) << FRAC_BITS;
         mag1_ff   <= MW'(abs1) << FRAC_BITS;
         neg0_b_ff <= n0_a_ff[NW-1] != ws_a_ff[D];
         neg1_b_ff <= n1_a_ff[NW-1] != ws_a_ff[D];
         wl_b_ff   <= wl_a_ff;
         ws_b_ff   <= ws_a_ff;
         aws_b_ff  <= aws_a_ff;
      end
   end

   // stage c: singularity test, quotient overflow, division setup
   logic vc_ff;
   logic [TW-1:0] lhs;
   logic [XW-1:0] den_top;
   logic ok_c_ff, ovf0_c_ff, ovf1_c_ff, neg0_c_ff, neg1_c_ff;
   logic [DW-1:0] rem0_c_ff, rem1_c_ff, den_c_ff;
   logic [D-1:0] low0_c_ff, low1_c_ff;
   logic [D:0] wl_c_ff;
   logic signed [D:0] ws_c_ff;
   logic [MW-1:0] top0, top1;

   always_comb begin
      lhs     = TW'({aws_b_ff, TOL_WIDTH'(0)});
      den_top = XW'(den_b_ff) << D;
      top0    = mag0_ff >> D;
      top1    = mag1_ff >> D;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (advance) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_c_ff   <= !(lhs <= tolp_ff);
         ovf0_c_ff <= XW'(mag0_ff) >= den_top;
         ovf1_c_ff <= XW'(mag1_ff) >= den_top;
         rem0_c_ff <= DW'(top0);
         rem1_c_ff <= DW'(top1);
         low0_c_ff <= mag0_ff[D-1:0];
         low1_c_ff <= mag1_ff[D-1:0];
         den_c_ff  <= den_b_ff;
         neg0_c_ff <= neg0_b_ff;
         neg1_c_ff <= neg1_b_ff;
         wl_c_ff   <= wl_b_ff;
         ws_c_ff   <= ws_b_ff;
      end
   end

   // divider chains
   logic [DW-1:0] d0_rem [D+1];
   logic [DW-1:0] d0_den [D+1];
   logic [D-1:0]  d0_quo [D+1];
   logic [D-1:0]  d0_low [D+1];
   logic [DW-1:0] d1_rem [D+1];
   logic [DW-1:0] d1_den [D+1];
   logic [D-1:0]  d1_quo [D+1];
   logic [D-1:0]  d1_low [D+1];
   logic          dv_v_ff    [D+1];
   logic          dv_ok_ff   [D+1];
   logic          dv_ovf0_ff [D+1];
   logic          dv_ovf1_ff [D+1];
   logic          dv_neg0_ff [D+1];
   logic          dv_neg1_ff [D+1];
   logic [D:0]    dv_wl_ff   [D+1];
   logic [D:0]    dv_ws_ff   [D+1];

   assign d0_rem[0] = rem0_c_ff;
   assign d0_den[0] = den_c_ff;
   assign d0_quo[0] = '0;
   assign d0_low[0] = low0_c_ff;
   assign d1_rem[0] = rem1_c_ff;
   assign d1_den[0] = den_c_ff;
   assign d1_quo[0] = '0;
   assign d1_low[0] = low1_c_ff;

   always_comb begin
      dv_v_ff[0]    = vc_ff;
      dv_ok_ff[0]   = ok_c_ff;
      dv_ovf0_ff[0] = ovf0_c_ff;
      dv_ovf1_ff[0] = ovf1_c_ff;
      dv_neg0_ff[0] = neg0_c_ff;
      dv_neg1_ff[0] = neg1_c_ff;
      dv_wl_ff[0]   = wl_c_ff;
      dv_ws_ff[0]   = ws_c_ff;
   end

   for (genvar j = 0; j < D; j++) begin : g_div
      svdsv_div_cell #(.DW(DW), .QW(D)) u_q0 (
         .clock   (clock),
         .advance (advance),
         .in_rem  (d0_rem[j]),
         .in_den  (d0_den[j]),
         .in_quo  (d0_quo[j]),
         .in_low  (d0_low[j]),
         .out_rem (d0_rem[j+1]),
         .out_den (d0_den[j+1]),
         .out_quo (d0_quo[j+1]),
         .out_low (d0_low[j+1])
      );
      svdsv_div_cell #(.DW(DW), .QW(D)) u_q1 (
         .clock   (clock),
         .advance (advance),
         .in_rem  (d1_rem[j]),
         .in_den  (d1_den[j]),
         .in_quo  (d1_quo[j]),
         .in_low  (d1_low[j]),
         .out_rem (d1_rem[j+1]),
         .out_den (d1_den[j+1]),
         .out_quo (d1_quo[j+1]),
         .out_low (d1_low[j+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (advance) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ok_ff[j+1]   <= dv_ok_ff[j];
            dv_ovf0_ff[j+1] <= dv_ovf0_ff[j];
            dv_ovf1_ff[j+1] <= dv_ovf1_ff[j];
            dv_neg0_ff[j+1] <= dv_neg0_ff[j];
            dv_neg1_ff[j+1] <= dv_neg1_ff[j];
            dv_wl_ff[j+1]   <= dv_wl_ff[j];
            dv_ws_ff[j+1]   <= dv_ws_ff[j];
         end
      end
   end

   // output register
   localparam logic [D-1:0] POS_MAX = {1'b0, {(D-1){1'b1}}};
   localparam logic [D-1:0] NEG_MAX = {1'b1, {(D-1){1'b0}}};

   logic neg0, neg1;
   logic [D-1:0] lim0, lim1, m0, m1;
   logic [D-1:0] sol0_in, sol1_in, large_in, small_in;
   logic signed [D:0] ws_last;
   logic rsp_valid_ff, solvable_ff;
   logic [D-1:0] sol0_ff, sol1_ff, large_ff, small_ff;

   always_comb begin
      neg0    = dv_neg0_ff[D] && (dv_ovf0_ff[D] || d0_quo[D] != '0);
      neg1    = dv_neg1_ff[D] && (dv_ovf1_ff[D] || d1_quo[D] != '0);
      lim0    = neg0 ? NEG_MAX : POS_MAX;
      lim1    = neg1 ? NEG_MAX : POS_MAX;
      m0      = (dv_ovf0_ff[D] || d0_quo[D] > lim0) ? lim0 : d0_quo[D];
      m1      = (dv_ovf1_ff[D] || d1_quo[D] > lim1) ? lim1 : d1_quo[D];
      sol0_in = !dv_ok_ff[D] ? '0 : (neg0 ? D'(-m0) : m0);
      sol1_in = !dv_ok_ff[D] ? '0 : (neg1 ? D'(-m1) : m1);
      large_in = dv_wl_ff[D][D] ? '1 : dv_wl_ff[D][D-1:0];
      ws_last  = signed'(dv_ws_ff[D]);
      if (ws_last > signed'((D+1)'(POS_MAX))) begin
         small_in = POS_MAX;
      end else if (ws_last < -signed'((D+1)'(NEG_MAX))) begin
         small_in = NEG_MAX;
      end else begin
         small_in = ws_last[D-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_v_ff[D];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sol0_ff     <= sol0_in;
         sol1_ff     <= sol1_in;
         large_ff    <= large_in;
         small_ff    <= small_in;
         solvable_ff <= dv_ok_ff[D];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sol0       = signed'(sol0_ff);
   assign rsp_sol1       = signed'(sol1_ff);
   assign rsp_sing_large = large_ff;
   assign rsp_sing_small = signed'(small_ff);
   assign rsp_solvable   = solvable_ff;

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_solvable |-> rsp_sol0 == '0 && rsp_sol1 == '0)
      else $error("singular system with nonzero solution");

   a_solvable_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_solvable |-> rsp_sing_small != '0)
      else $error("solvable system with zero small singular value");

endmodule
